FILE: rtl/core/debounced_adc_window_detector_assert.svh
// Assertion macros shared by the accessory detector RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef DEBOUNCED_ADC_WINDOW_DETECTOR_ASSERT_SVH
`define DEBOUNCED_ADC_WINDOW_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAWD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define DAWD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/core/dawd_pkg.sv
// Shared types and constants for the debounced ADC window detector.
// No dependencies; used by dawd_classify and the top level.
`timescale 1ns / 1ps

package dawd_pkg;

  // Default widths of the millivolt values and of the tick countdown.
  localparam int DEF_MV_WIDTH    = 12;
  localparam int DEF_COUNT_WIDTH = 10;

  // Register reset values, cut to the configured widths where they are used.
  localparam logic [31:0] RST_DETACHED_LOW_MV  = 32'd2700;
  localparam logic [31:0] RST_DETACHED_HIGH_MV = 32'd3500;
  localparam logic [31:0] RST_DOCK_LOW_MV      = 32'd141;
  localparam logic [31:0] RST_DOCK_HIGH_MV     = 32'd173;
  localparam logic [31:0] RST_KEYBOARD_LOW_MV  = 32'd270;
  localparam logic [31:0] RST_KEYBOARD_HIGH_MV = 32'd400;
  localparam logic [31:0] RST_DEBOUNCE_TICKS   = 32'd20;
  localparam logic [31:0] RST_RETRY_TICKS      = 32'd500;

  localparam int REG_INDEX_W = 3;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes.
  typedef enum logic [REG_INDEX_W-1:0] {
    REG_DETACHED_LOW  = 3'd0,
    REG_DETACHED_HIGH = 3'd1,
    REG_DOCK_LOW      = 3'd2,
    REG_DOCK_HIGH     = 3'd3,
    REG_KEYBOARD_LOW  = 3'd4,
    REG_KEYBOARD_HIGH = 3'd5,
    REG_DEBOUNCE      = 3'd6,
    REG_RETRY         = 3'd7
  } reg_index_t;

  // Input word kinds carried on tuser.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_EDGE   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  // Classification of a sample.
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_ERROR    = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_DETACHED = 3'd3,
    KIND_DOCK     = 3'd4,
    KIND_KEYBOARD = 3'd5
  } kind_t;

  // One result word; the last member lands in the lowest bit.
  typedef struct packed {
    kind_t device_kind;
    logic  charge_update;
    logic  charge_enable;
    logic  power_enable;
    logic  sample_request;
  } result_t;

endpackage

FILE: rtl/core/dawd_classify.sv
// Sample classifier: tests a reading against the three voltage windows.
// Depends on dawd_pkg for the kind codes.
`timescale 1ns / 1ps

module dawd_classify #(
  parameter int MV_WIDTH = dawd_pkg::DEF_MV_WIDTH
) (
  input  logic [MV_WIDTH-1:0] mv,
  input  logic                err,
  input  logic [MV_WIDTH-1:0] detached_low,
  input  logic [MV_WIDTH-1:0] detached_high,
  input  logic [MV_WIDTH-1:0] dock_low,
  input  logic [MV_WIDTH-1:0] dock_high,
  input  logic [MV_WIDTH-1:0] keyboard_low,
  input  logic [MV_WIDTH-1:0] keyboard_high,
  output dawd_pkg::kind_t     kind
);

  logic in_detached;
  logic in_dock;
  logic in_keyboard;

  // An inverted window can never satisfy both bounds, so it never matches.
  assign in_detached = (detached_low <= mv) && (mv <= detached_high);
  assign in_dock     = (dock_low <= mv) && (mv <= dock_high);
  assign in_keyboard = (keyboard_low <= mv) && (mv <= keyboard_high);

  // Priority order: error, detached, dock, keyboard, then unknown.
  always_comb begin
    if (err) begin
      kind = dawd_pkg::KIND_ERROR;
    end else if (in_detached) begin
      kind = dawd_pkg::KIND_DETACHED;
    end else if (in_dock) begin
      kind = dawd_pkg::KIND_DOCK;
    end else if (in_keyboard) begin
      kind = dawd_pkg::KIND_KEYBOARD;
    end else begin
      kind = dawd_pkg::KIND_UNKNOWN;
    end
  end

endmodule

FILE: rtl/core/debounced_adc_window_detector.sv
// Top level of the debounced ADC window detector.
// Depends on dawd_pkg, dawd_classify and debounced_adc_window_detector_assert.svh.
//
// Usage:
//   s_axis carries input words. tuser holds the kind (tick, detect-pin edge,
//   ADC sample); tdata holds adc_mv and adc_error. Every accepted word gives
//   exactly one result word on m_axis, whose tdata holds sample_request,
//   power_enable, charge_enable, charge_update and device_kind.
//   A result is registered into the output register, or the skid stage if
//   the output stalls. Throughput: one word per cycle while s_axis_tready is
//   high; the state update for each word is a single pass through the countdown and
//   window compares. Configuration: cfg_we writes cfg_data into register
//   cfg_index; write only while no word is in flight.
//   Reset: rst clears the outputs and the pending-sample flag, loads all
//   registers with their defaults and arms the check with a zero countdown,
//   so the first tick after reset requests a sample.
//   Stall: results wait in an output register backed by one skid stage. When
//   both hold a word, s_axis_tready drops until m_axis_tready frees one.
`timescale 1ns / 1ps
`include "debounced_adc_window_detector_assert.svh"

module debounced_adc_window_detector #(
  parameter int MV_WIDTH    = dawd_pkg::DEF_MV_WIDTH,
  parameter int COUNT_WIDTH = dawd_pkg::DEF_COUNT_WIDTH,
  localparam int InTdataW   = ((MV_WIDTH + 1 + 7) / 8) * 8,
  localparam int CfgW       = (MV_WIDTH > COUNT_WIDTH) ? MV_WIDTH : COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [dawd_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [CfgW-1:0]                     cfg_data,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [InTdataW-1:0]                 s_axis_tdata,  // adc_mv, adc_error, zero pad
  input  logic [1:0]                          s_axis_tuser,  // operation
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dawd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // sample_request, power_enable,
                                                             // charge_enable, charge_update,
                                                             // device_kind, zero pad
);

  // Configuration registers.
  logic [MV_WIDTH-1:0]    detached_low;
  logic [MV_WIDTH-1:0]    detached_high;
  logic [MV_WIDTH-1:0]    dock_low;
  logic [MV_WIDTH-1:0]    dock_high;
  logic [MV_WIDTH-1:0]    keyboard_low;
  logic [MV_WIDTH-1:0]    keyboard_high;
  logic [COUNT_WIDTH-1:0] debounce_ticks;
  logic [COUNT_WIDTH-1:0] retry_ticks;

  // Detector state.
  logic [COUNT_WIDTH-1:0] check_countdown;
  logic [COUNT_WIDTH-1:0] check_countdown_next;
  logic                   check_armed;
  logic                   check_armed_next;
  logic                   awaiting_sample;
  logic                   awaiting_sample_next;
  logic                   power_on;
  logic                   power_on_next;
  logic                   charge_on;
  logic                   charge_on_next;

  // Output register and skid stage.
  dawd_pkg::result_t      out_data;
  logic                   out_valid;
  dawd_pkg::result_t      skid_data;
  logic                   skid_valid;

  logic                   accept;
  logic [MV_WIDTH-1:0]    in_mv;
  logic                   in_err;
  dawd_pkg::op_t          in_op;
  dawd_pkg::kind_t        sample_kind;
  dawd_pkg::result_t      result;

  assign in_mv  = s_axis_tdata[MV_WIDTH-1:0];
  assign in_err = s_axis_tdata[MV_WIDTH];
  assign in_op  = dawd_pkg::op_t'(s_axis_tuser);

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      detached_low   <= dawd_pkg::RST_DETACHED_LOW_MV[MV_WIDTH-1:0];
      detached_high  <= dawd_pkg::RST_DETACHED_HIGH_MV[MV_WIDTH-1:0];
      dock_low       <= dawd_pkg::RST_DOCK_LOW_MV[MV_WIDTH-1:0];
      dock_high      <= dawd_pkg::RST_DOCK_HIGH_MV[MV_WIDTH-1:0];
      keyboard_low   <= dawd_pkg::RST_KEYBOARD_LOW_MV[MV_WIDTH-1:0];
      keyboard_high  <= dawd_pkg::RST_KEYBOARD_HIGH_MV[MV_WIDTH-1:0];
      debounce_ticks <= dawd_pkg::RST_DEBOUNCE_TICKS[COUNT_WIDTH-1:0];
      retry_ticks    <= dawd_pkg::RST_RETRY_TICKS[COUNT_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (dawd_pkg::reg_index_t'(cfg_index))
        dawd_pkg::REG_DETACHED_LOW:  detached_low   <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_DETACHED_HIGH: detached_high  <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_DOCK_LOW:      dock_low       <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_DOCK_HIGH:     dock_high      <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_KEYBOARD_LOW:  keyboard_low   <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_KEYBOARD_HIGH: keyboard_high  <= cfg_data[MV_WIDTH-1:0];
        dawd_pkg::REG_DEBOUNCE:      debounce_ticks <= cfg_data[COUNT_WIDTH-1:0];
        dawd_pkg::REG_RETRY:         retry_ticks    <= cfg_data[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  dawd_classify #(
    .MV_WIDTH(MV_WIDTH)
  ) u_classify (
    .mv           (in_mv),
    .err          (in_err),
    .detached_low (detached_low),
    .detached_high(detached_high),
    .dock_low     (dock_low),
    .dock_high    (dock_high),
    .keyboard_low (keyboard_low),
    .keyboard_high(keyboard_high),
    .kind         (sample_kind)
  );

  // Next state and result for the word on the input.
  always_comb begin
    check_countdown_next  = check_countdown;
    check_armed_next      = check_armed;
    awaiting_sample_next  = awaiting_sample;
    power_on_next         = power_on;
    charge_on_next        = charge_on;
    result.sample_request = 1'b0;
    result.charge_update  = 1'b0;
    result.device_kind    = dawd_pkg::KIND_NONE;

    unique case (in_op)
      dawd_pkg::OP_TICK: begin
        // A count of zero or one fires on this tick.
        if (check_armed) begin
          if (check_countdown <= COUNT_WIDTH'(1)) begin
            check_countdown_next  = '0;
            check_armed_next      = 1'b0;
            awaiting_sample_next  = 1'b1;
            result.sample_request = 1'b1;
          end else begin
            check_countdown_next = check_countdown - COUNT_WIDTH'(1);
          end
        end
      end
      dawd_pkg::OP_EDGE: begin
        // Restart the debounce and drop any sample still pending as stale.
        check_countdown_next = debounce_ticks;
        check_armed_next     = 1'b1;
        awaiting_sample_next = 1'b0;
      end
      dawd_pkg::OP_SAMPLE: begin
        // Samples that were not requested are ignored.
        if (awaiting_sample) begin
          awaiting_sample_next = 1'b0;
          result.device_kind   = sample_kind;
          case (sample_kind)
            dawd_pkg::KIND_DETACHED: begin
              power_on_next        = 1'b0;
              charge_on_next       = 1'b0;
              result.charge_update = 1'b1;
            end
            dawd_pkg::KIND_DOCK: begin
              power_on_next        = 1'b0;
              charge_on_next       = 1'b1;
              result.charge_update = 1'b1;
            end
            dawd_pkg::KIND_KEYBOARD: begin
              power_on_next        = 1'b1;
              charge_on_next       = 1'b0;
              result.charge_update = 1'b1;
            end
            default: begin
              // Error or unknown reading: try again after the retry interval.
              check_countdown_next = retry_ticks;
              check_armed_next     = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    result.power_enable  = power_on_next;
    result.charge_enable = charge_on_next;
  end

  // State registers update only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_countdown <= '0;
      check_armed     <= 1'b1;
      awaiting_sample <= 1'b0;
      power_on        <= 1'b0;
      charge_on       <= 1'b0;
    end else if (accept) begin
      check_countdown <= check_countdown_next;
      check_armed     <= check_armed_next;
      awaiting_sample <= awaiting_sample_next;
      power_on        <= power_on_next;
      charge_on       <= charge_on_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && m_axis_tready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || m_axis_tready) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_valid && m_axis_tready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(dawd_pkg::OUT_TDATA_W - $bits(dawd_pkg::result_t)){1'b0}}, out_data};

  // The skid stage only fills behind a held output word.
  `DAWD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  // A word arriving against a stalled, full output register lands in the skid.
  `DAWD_ASSERT_NEXT(a_skid_fills,
    accept && out_valid && !m_axis_tready, skid_valid)
  // A sample request leaves the detector waiting with the countdown disarmed.
  `DAWD_ASSERT_NEXT(a_request_waits,
    accept && result.sample_request, awaiting_sample && !check_armed)
  // Any accepted sample ends the wait.
  `DAWD_ASSERT_NEXT(a_sample_ends_wait,
    accept && (in_op == dawd_pkg::OP_SAMPLE), !awaiting_sample)
  // An update only follows a matched window.
  `DAWD_ASSERT_NOW(a_update_on_match, result.charge_update,
    (result.device_kind == dawd_pkg::KIND_DETACHED) ||
    (result.device_kind == dawd_pkg::KIND_DOCK) ||
    (result.device_kind == dawd_pkg::KIND_KEYBOARD))

endmodule

FILE: sim/debounced_adc_window_detector_tb.sv
// Self-checking testbench for the debounced ADC window detector.
// Needs dawd_pkg and the debounced_adc_window_detector RTL; reads no files.
`timescale 1ns / 1ps

module debounced_adc_window_detector_tb;
  import dawd_pkg::*;

  // The operation field is two bits wide; code 3 is left unused by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_WORDS = 85;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic [1:0]  op;
    logic [11:0] mv;
    logic        err;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;

  // Shadow copy of the registers and of the detector state.
  logic [11:0] reg_shadow [8];
  logic [9:0]  sh_count;
  logic        sh_armed;
  logic        sh_waiting;
  logic        sh_power;
  logic        sh_charge;

  result_t     expected_results [$];
  stim_row_t   directed_rows [25];
  int          fail_count = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_req = 1'b0;

  debounced_adc_window_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic result_t mk_res(kind_t k, logic upd, logic chg, logic pwr, logic req);
    result_t r;
    r.device_kind    = k;
    r.charge_update  = upd;
    r.charge_enable  = chg;
    r.power_enable   = pwr;
    r.sample_request = req;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] op, logic [11:0] mv, logic err, bit typed,
                                       result_t res);
    stim_row_t row;
    row.op    = op;
    row.mv    = mv;
    row.err   = err;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  function automatic bit in_window(logic [11:0] mv, logic [11:0] lo, logic [11:0] hi);
    return (lo <= mv) && (mv <= hi);
  endfunction

  // Windows are tried in priority order; an inverted window never matches.
  function automatic kind_t classify_mv(logic [11:0] mv, logic err);
    if (err) return KIND_ERROR;
    if (in_window(mv, reg_shadow[REG_DETACHED_LOW], reg_shadow[REG_DETACHED_HIGH]))
      return KIND_DETACHED;
    if (in_window(mv, reg_shadow[REG_DOCK_LOW], reg_shadow[REG_DOCK_HIGH]))
      return KIND_DOCK;
    if (in_window(mv, reg_shadow[REG_KEYBOARD_LOW], reg_shadow[REG_KEYBOARD_HIGH]))
      return KIND_KEYBOARD;
    return KIND_UNKNOWN;
  endfunction

  // Advances the shadow detector by one input word and returns its result word.
  function automatic result_t advance_detector(logic [1:0] op, logic [11:0] mv, logic err);
    result_t r;
    kind_t   k;
    r = mk_res(KIND_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    k = KIND_NONE;
    case (op)
      OP_TICK: begin
        if (sh_armed) begin
          if (sh_count <= 10'd1) begin
            sh_count   = '0;
            sh_armed   = 1'b0;
            sh_waiting = 1'b1;
            r.sample_request = 1'b1;
          end else begin
            sh_count = sh_count - 10'd1;
          end
        end
      end
      OP_EDGE: begin
        sh_count   = reg_shadow[REG_DEBOUNCE][9:0];
        sh_armed   = 1'b1;
        sh_waiting = 1'b0;
      end
      OP_SAMPLE: begin
        if (sh_waiting) begin
          sh_waiting = 1'b0;
          k = classify_mv(mv, err);
          case (k)
            KIND_DETACHED: begin
              sh_power = 1'b0;
              sh_charge = 1'b0;
              r.charge_update = 1'b1;
            end
            KIND_DOCK: begin
              sh_power = 1'b0;
              sh_charge = 1'b1;
              r.charge_update = 1'b1;
            end
            KIND_KEYBOARD: begin
              sh_power = 1'b1;
              sh_charge = 1'b0;
              r.charge_update = 1'b1;
            end
            default: begin
              // Error or no window matched: retry later.
              sh_count = reg_shadow[REG_RETRY][9:0];
              sh_armed = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
    r.device_kind   = k;
    r.power_enable  = sh_power;
    r.charge_enable = sh_charge;
    return r;
  endfunction

  // Mostly back-to-back words, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Sample voltages lean toward window bounds and window interiors.
  function automatic logic [11:0] pick_mv();
    int w;
    int r;
    logic [11:0] lo;
    logic [11:0] hi;
    w  = $urandom_range(0, 2);
    lo = reg_shadow[2 * w];
    hi = reg_shadow[2 * w + 1];
    r  = $urandom_range(0, 9);
    case (r)
      0: return lo;
      1: return hi;
      2: return lo - 12'd1;
      3: return hi + 12'd1;
      4, 5, 6: begin
        if (lo <= hi) return lo + 12'($urandom_range(0, hi - lo));
        return 12'($urandom);
      end
      default: return 12'($urandom);
    endcase
  endfunction

  // Offers one word, waits until it is taken, and records its expected result.
  task automatic send_word(logic [1:0] op, logic [11:0] mv, logic err, bit typed,
                           result_t res);
    result_t predicted;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, err, mv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = advance_detector(op, mv, err);
    expected_results.push_back(typed ? res : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering words and waits for every expected result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all eight registers, one per cycle, and mirrors them.
  task automatic load_registers(logic [11:0] vals [8]);
    reg_index_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      @(posedge clk);
      if (idx == REG_DEBOUNCE || idx == REG_RETRY) reg_shadow[idx] = {2'b00, vals[idx][9:0]};
      else reg_shadow[idx] = vals[idx];
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: checks every accepted word and stalls at random.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    result_t got;
    result_t want;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tready && m_axis_tvalid) begin
        got = result_t'(m_axis_tdata[6:0]);
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result word %h.", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.sample_request !== want.sample_request ||
              got.power_enable !== want.power_enable ||
              got.charge_enable !== want.charge_enable ||
              got.charge_update !== want.charge_update ||
              got.device_kind !== want.device_kind) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected req=%0b pwr=%0b chg=%0b upd=%0b kind=%0d, got req=%0b pwr=%0b chg=%0b upd=%0b kind=%0d",
                       want.sample_request, want.power_enable, want.charge_enable,
                       want.charge_update, want.device_kind, got.sample_request,
                       got.power_enable, got.charge_enable, got.charge_update,
                       got.device_kind);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 70) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(15, 40);
        m_tready <= 1'b0;
      end
    end
  end

  // Input side: directed table, then phases of random words under several settings.
  initial begin : stimulus
    logic [11:0] setting [8];
    logic [1:0]  op;
    logic [11:0] mv;
    logic        err;
    int          r;
    int          a;
    int          b;

    reg_shadow[REG_DETACHED_LOW]  = RST_DETACHED_LOW_MV[11:0];
    reg_shadow[REG_DETACHED_HIGH] = RST_DETACHED_HIGH_MV[11:0];
    reg_shadow[REG_DOCK_LOW]      = RST_DOCK_LOW_MV[11:0];
    reg_shadow[REG_DOCK_HIGH]     = RST_DOCK_HIGH_MV[11:0];
    reg_shadow[REG_KEYBOARD_LOW]  = RST_KEYBOARD_LOW_MV[11:0];
    reg_shadow[REG_KEYBOARD_HIGH] = RST_KEYBOARD_HIGH_MV[11:0];
    reg_shadow[REG_DEBOUNCE]      = {2'b00, RST_DEBOUNCE_TICKS[9:0]};
    reg_shadow[REG_RETRY]         = {2'b00, RST_RETRY_TICKS[9:0]};
    sh_count   = '0;
    sh_armed   = 1'b1;
    sh_waiting = 1'b0;
    sh_power   = 1'b0;
    sh_charge  = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part: default windows, zero debounce and zero retry interval.
    setting = reg_shadow;
    setting[REG_DEBOUNCE] = 12'd0;
    setting[REG_RETRY]    = 12'd0;
    load_registers(setting);

    // A sample before any request is ignored; the first tick after reset fires.
    directed_rows[0]  = mk_row(OP_SAMPLE, 12'd3000, 1'b0, 1'b1,
                               mk_res(KIND_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    directed_rows[1]  = mk_row(OP_TICK, 12'd0, 1'b0, 1'b1,
                               mk_res(KIND_NONE, 1'b0, 1'b0, 1'b0, 1'b1));
    directed_rows[2]  = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[3]  = mk_row(OP_SAMPLE, 12'd157, 1'b0, 1'b0, '0);
    directed_rows[4]  = mk_row(OP_UNUSED, 12'd4095, 1'b1, 1'b0, '0);
    directed_rows[5]  = mk_row(OP_EDGE, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[6]  = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    // Failed conversion, then an unmatched full-scale reading.
    directed_rows[7]  = mk_row(OP_SAMPLE, 12'd0, 1'b1, 1'b1,
                               mk_res(KIND_ERROR, 1'b0, 1'b1, 1'b0, 1'b0));
    directed_rows[8]  = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[9]  = mk_row(OP_SAMPLE, 12'd4095, 1'b0, 1'b1,
                               mk_res(KIND_UNKNOWN, 1'b0, 1'b1, 1'b0, 1'b0));
    directed_rows[10] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    // An edge while a sample is pending makes that sample stale.
    directed_rows[11] = mk_row(OP_EDGE, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[12] = mk_row(OP_SAMPLE, 12'd300, 1'b0, 1'b0, '0);
    directed_rows[13] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[14] = mk_row(OP_SAMPLE, 12'd300, 1'b0, 1'b0, '0);
    directed_rows[15] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[16] = mk_row(OP_EDGE, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[17] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    // Both bounds of a window are inclusive.
    directed_rows[18] = mk_row(OP_SAMPLE, 12'd2700, 1'b0, 1'b1,
                               mk_res(KIND_DETACHED, 1'b1, 1'b0, 1'b0, 1'b0));
    directed_rows[19] = mk_row(OP_EDGE, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[20] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[21] = mk_row(OP_SAMPLE, 12'd3500, 1'b0, 1'b1,
                               mk_res(KIND_DETACHED, 1'b1, 1'b0, 1'b0, 1'b0));
    directed_rows[22] = mk_row(OP_EDGE, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[23] = mk_row(OP_TICK, 12'd0, 1'b0, 1'b0, '0);
    directed_rows[24] = mk_row(OP_SAMPLE, 12'd173, 1'b0, 1'b0, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].mv, directed_rows[i].err,
                directed_rows[i].typed, directed_rows[i].res);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          // Reset values.
          setting[REG_DETACHED_LOW]  = RST_DETACHED_LOW_MV[11:0];
          setting[REG_DETACHED_HIGH] = RST_DETACHED_HIGH_MV[11:0];
          setting[REG_DOCK_LOW]      = RST_DOCK_LOW_MV[11:0];
          setting[REG_DOCK_HIGH]     = RST_DOCK_HIGH_MV[11:0];
          setting[REG_KEYBOARD_LOW]  = RST_KEYBOARD_LOW_MV[11:0];
          setting[REG_KEYBOARD_HIGH] = RST_KEYBOARD_HIGH_MV[11:0];
          setting[REG_DEBOUNCE]      = RST_DEBOUNCE_TICKS[11:0];
          setting[REG_RETRY]         = RST_RETRY_TICKS[11:0];
        end
        1: foreach (setting[i]) setting[i] = 12'd0;
        2: begin
          foreach (setting[i]) setting[i] = 12'hfff;
          setting[REG_DEBOUNCE] = 12'd1023;
          setting[REG_RETRY]    = 12'd1023;
        end
        default: begin
          // Random windows, some inverted, with short countdowns.
          for (int w = 0; w < 3; w++) begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
            if ((a > b) == ($urandom_range(0, 3) != 0)) begin
              setting[2 * w]     = 12'(b);
              setting[2 * w + 1] = 12'(a);
            end else begin
              setting[2 * w]     = 12'(a);
              setting[2 * w + 1] = 12'(b);
            end
          end
          setting[REG_DEBOUNCE] = 12'($urandom_range(0, 6));
          setting[REG_RETRY]    = 12'($urandom_range(0, 6));
        end
      endcase
      load_registers(setting);
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Long receiver hold-off while words keep coming.
        if (phase == 4 && n == 20) hold_req = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 8) begin
          op  = OP_EDGE;
          mv  = 12'($urandom);
          err = 1'($urandom);
        end else if (r < 14) begin
          op  = 2'($urandom);
          mv  = 12'($urandom);
          err = 1'($urandom);
        end else if (sh_waiting) begin
          op  = OP_SAMPLE;
          mv  = pick_mv();
          err = ($urandom_range(0, 9) == 0);
        end else begin
          op  = OP_TICK;
          mv  = 12'($urandom);
          err = 1'($urandom);
        end
        send_word(op, mv, err, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
